// ----- src/chl_pkg.sv -----
// ----------------------------------------------------------------------------
// chl_pkg: shared definitions for the coordinate hash lookup-or-insert block
// Table sizes, hashing constants, controller states and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package chl_pkg;

    localparam int BUCKETS    = 1024;
    localparam int MAX_NODES  = 4095;
    localparam int COORD_BITS = 32;

    localparam int COORD_W = 32;   // input field width
    localparam int ID_W    = 12;   // node id / chain link width
    localparam int CNT_W   = 11;   // bucket_count register width
    localparam int BKT_AW  = $clog2(BUCKETS);
    localparam int NODE_AW = $clog2(MAX_NODES);
    localparam int NODE_W  = 2 * COORD_W + ID_W;

    localparam logic [COORD_W-1:0] COORD_MASK =
        COORD_W'((64'd1 << COORD_BITS) - 64'd1);

    // golden-ratio fraction (sqrt(5)-1)/2 as unsigned 0.64, truncated
    localparam logic [63:0] GOLDEN_Q064 = 64'h9E3779B97F4A7C15;

    // APB register map
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-3:0] REG_BUCKET_COUNT = '0;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TRI,
        ST_SUM,
        ST_KEY,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_M6,
        ST_BKT,
        ST_HEAD_RD,
        ST_HEAD_GOT,
        ST_WALK,
        ST_CMP,
        ST_INSERT,
        ST_RES_FOUND,
        ST_RES_NEW,
        ST_RES_FULL
    } state_t;

    typedef enum logic [2:0] {
        MUL_ST,
        MUL_KLGL,
        MUL_KHGL,
        MUL_KLGH,
        MUL_CLO,
        MUL_CHI
    } mul_sel_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CROSS,
        OP_TRI,
        OP_KEY,
        OP_ACC_LOAD,
        OP_ACC_ADD,
        OP_CARRY,
        OP_BUCKET
    } dp_op_t;

    typedef enum logic [1:0] {
        RK_FOUND,
        RK_NEW,
        RK_FULL
    } res_kind_t;

    typedef struct packed {
        logic      load_in;
        mul_sel_t  mul_sel;
        dp_op_t    op;
        logic      clr_write;
        logic      cur_head;
        logic      cur_next;
        logic      insert;
        logic      res_load;
        res_kind_t res_kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic cur_end;
        logic match;
        logic full;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- src/coordinate_hash_lookup_or_insert.sv -----
// ----------------------------------------------------------------------------
// coordinate_hash_lookup_or_insert: point lookup-or-insert hash table
// Keys (x, y) by Cantor pairing, hashes by 64-bit Fibonacci hashing, walks
// the bucket chain and returns the found id or inserts the point.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 1024-entry bucket head memory to zero,
// one entry per cycle, and holds s_tready low until the sweep ends; APB
// writes are taken during the sweep. It then works on one point at a time.
// For each point it hashes the key by six passes through one shared 32x32
// multiplier, reads the bucket head, and for each chain entry makes a
// registered read of the node memory plus a compare; it then returns the
// found id, inserts the point or reports a full store. s_tready rises again
// with m_tvalid: a finished result waits in the output register while the
// next point is taken in, and the next result waits until that register is
// free.
`default_nettype none

module coordinate_hash_lookup_or_insert (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input points
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [2*chl_pkg::COORD_W-1:0]     s_tdata,  // coord_x, coord_y
    // results
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [15:0]                       m_tdata,  // node_id, zero pad
    output logic      [1:0]                        m_tuser,  // was_found, store_full
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [chl_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [chl_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [chl_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                   pready
);

    logic [chl_pkg::CNT_W-1:0] bucket_count_reg;
    logic                      reg_sel;
    chl_pkg::ctrl_cmd_t        cmd;
    chl_pkg::dp_status_t       status;
    logic [chl_pkg::ID_W-1:0]  out_id;
    logic                      out_found, out_full;

    assign reg_sel = (paddr[chl_pkg::CFG_ADDR_W-1:2] == chl_pkg::REG_BUCKET_COUNT);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= chl_pkg::CNT_W'(chl_pkg::BUCKETS);
        end else if (psel && penable && pwrite && reg_sel) begin
            bucket_count_reg <= pwdata[chl_pkg::CNT_W-1:0];
        end
    end

    assign prdata = reg_sel ?
        {{(chl_pkg::CFG_DATA_W-chl_pkg::CNT_W){1'b0}}, bucket_count_reg} : '0;

    chl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    chl_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .in_x             (s_tdata[chl_pkg::COORD_W-1:0]),
        .in_y             (s_tdata[2*chl_pkg::COORD_W-1:chl_pkg::COORD_W]),
        .cfg_bucket_count (bucket_count_reg),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_id           (out_id),
        .out_found        (out_found),
        .out_full         (out_full)
    );

    assign m_tdata = {{(16-chl_pkg::ID_W){1'b0}}, out_id};
    assign m_tuser = {out_full, out_found};

endmodule

`default_nettype wire

// ----- src/chl_ram.sv -----
// ----------------------------------------------------------------------------
// chl_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module chl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/chl_datapath.sv -----
// ----------------------------------------------------------------------------
// chl_datapath: hashing, chain walk and result datapath
// Shared 32x32 multiplier for the Cantor key and Fibonacci hash, the bucket
// head and node memories, the node counter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module chl_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire chl_pkg::ctrl_cmd_t             cmd,
    output chl_pkg::dp_status_t                 status,
    input  wire logic [chl_pkg::COORD_W-1:0]    in_x,
    input  wire logic [chl_pkg::COORD_W-1:0]    in_y,
    input  wire logic [chl_pkg::CNT_W-1:0]      cfg_bucket_count,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [chl_pkg::ID_W-1:0]       out_id,
    output logic                                out_found,
    output logic                                out_full
);

    localparam int CW = chl_pkg::COORD_W;
    localparam int PW = 32 + chl_pkg::CNT_W;   // count * 32-bit half

    // item operands
    logic [CW-1:0]             x_reg, y_reg;
    logic [chl_pkg::CNT_W-1:0] count_reg;

    // hashing
    logic [63:0]               prod_reg;
    logic [35:0]               cross_reg, cross_next;
    logic [63:0]               tri_reg;
    logic [63:0]               key_reg;
    logic [63:0]               acc_reg;
    logic [chl_pkg::CNT_W-1:0] carry_reg;
    logic [chl_pkg::BKT_AW-1:0] bucket_reg;
    logic [31:0]               mul_a, mul_b;
    logic [32:0]               s_sum;
    logic [33:0]               t_sum;
    logic [65:0]               p_full;
    logic [PW-1:0]             t_bkt;

    // chain walk
    logic [chl_pkg::ID_W-1:0]   cur_reg, head_reg;
    logic [chl_pkg::ID_W-1:0]   node_count_reg;
    logic [chl_pkg::BKT_AW-1:0] clr_idx_reg;

    // memories
    logic                        bkt_we;
    logic [chl_pkg::BKT_AW-1:0]  bkt_waddr;
    logic [chl_pkg::ID_W-1:0]    bkt_wdata, bkt_rdata;
    logic [chl_pkg::NODE_W-1:0]  node_wdata, node_rdata;
    logic [chl_pkg::NODE_AW-1:0] node_raddr;

    // output stage
    logic                     out_valid_reg;
    logic [chl_pkg::ID_W-1:0] out_id_reg;
    logic                     out_found_reg, out_full_reg;

    // Cantor pairing: s = x + y, P = s * (s + 1), split so that only the low
    // 32x32 product needs the multiplier; the high parts are shifts and adds.
    assign s_sum = {1'b0, x_reg} + {1'b0, y_reg};
    assign t_sum = {1'b0, s_sum} + 34'd1;

    always_comb begin
        cross_next = '0;
        if (s_sum[32]) begin
            cross_next = cross_next + {4'b0, t_sum[31:0]};
        end
        if (t_sum[32]) begin
            cross_next = cross_next + {4'b0, s_sum[31:0]};
        end
        if (t_sum[33]) begin
            cross_next = cross_next + {3'b0, s_sum[31:0], 1'b0};
        end
        cross_next = cross_next + {2'b0, t_sum[33:32] & {2{s_sum[32]}}, 32'b0};
    end

    assign p_full = {2'b0, prod_reg} + {cross_reg[33:0], 32'b0};
    assign t_bkt  = prod_reg[PW-1:0] + {32'b0, carry_reg};

    always_comb begin
        case (cmd.mul_sel)
            chl_pkg::MUL_ST: begin
                mul_a = s_sum[31:0];
                mul_b = t_sum[31:0];
            end
            chl_pkg::MUL_KLGL: begin
                mul_a = key_reg[31:0];
                mul_b = chl_pkg::GOLDEN_Q064[31:0];
            end
            chl_pkg::MUL_KHGL: begin
                mul_a = key_reg[63:32];
                mul_b = chl_pkg::GOLDEN_Q064[31:0];
            end
            chl_pkg::MUL_KLGH: begin
                mul_a = key_reg[31:0];
                mul_b = chl_pkg::GOLDEN_Q064[63:32];
            end
            chl_pkg::MUL_CLO: begin
                mul_a = {{(32-chl_pkg::CNT_W){1'b0}}, count_reg};
                mul_b = acc_reg[31:0];
            end
            chl_pkg::MUL_CHI: begin
                mul_a = {{(32-chl_pkg::CNT_W){1'b0}}, count_reg};
                mul_b = acc_reg[63:32];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;

        if (cmd.load_in) begin
            x_reg <= in_x & chl_pkg::COORD_MASK;
            y_reg <= in_y & chl_pkg::COORD_MASK;
            if (cfg_bucket_count == '0) begin
                count_reg <= chl_pkg::CNT_W'(1);
            end else if (cfg_bucket_count > chl_pkg::CNT_W'(chl_pkg::BUCKETS)) begin
                count_reg <= chl_pkg::CNT_W'(chl_pkg::BUCKETS);
            end else begin
                count_reg <= cfg_bucket_count;
            end
        end

        case (cmd.op)
            chl_pkg::OP_CROSS:    cross_reg <= cross_next;
            chl_pkg::OP_TRI:      tri_reg <= p_full[64:1];
            chl_pkg::OP_KEY:      key_reg <= {32'b0, y_reg} + tri_reg;
            chl_pkg::OP_ACC_LOAD: acc_reg <= prod_reg;
            chl_pkg::OP_ACC_ADD:  acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
            chl_pkg::OP_CARRY:    carry_reg <= prod_reg[PW-1:32];
            chl_pkg::OP_BUCKET: begin
                if (t_bkt[PW-1:32] >= chl_pkg::CNT_W'(chl_pkg::BUCKETS)) begin
                    bucket_reg <= chl_pkg::BKT_AW'(chl_pkg::BUCKETS - 1);
                end else begin
                    bucket_reg <= t_bkt[32 +: chl_pkg::BKT_AW];
                end
            end
            default: begin
            end
        endcase

        if (cmd.cur_head) begin
            cur_reg  <= bkt_rdata;
            head_reg <= bkt_rdata;
        end else if (cmd.cur_next) begin
            cur_reg <= node_rdata[chl_pkg::NODE_W-1 -: chl_pkg::ID_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= '0;
            clr_idx_reg    <= '0;
        end else begin
            if (cmd.insert) begin
                node_count_reg <= node_count_reg + chl_pkg::ID_W'(1);
            end
            if (cmd.clr_write) begin
                clr_idx_reg <= clr_idx_reg + chl_pkg::BKT_AW'(1);
            end
        end
    end

    // bucket heads: cleared by a sweep after reset, else written on insert
    always_comb begin
        bkt_we    = cmd.clr_write | cmd.insert;
        bkt_waddr = cmd.clr_write ? clr_idx_reg : bucket_reg;
        bkt_wdata = cmd.clr_write ? '0 : node_count_reg + chl_pkg::ID_W'(1);
    end

    assign node_wdata = {head_reg, y_reg, x_reg};
    assign node_raddr = chl_pkg::NODE_AW'(cur_reg - chl_pkg::ID_W'(1));

    chl_ram #(
        .WIDTH (chl_pkg::ID_W),
        .DEPTH (chl_pkg::BUCKETS)
    ) u_bucket_ram (
        .aclk  (aclk),
        .we    (bkt_we),
        .waddr (bkt_waddr),
        .wdata (bkt_wdata),
        .raddr (bucket_reg),
        .rdata (bkt_rdata)
    );

    chl_ram #(
        .WIDTH (chl_pkg::NODE_W),
        .DEPTH (chl_pkg::MAX_NODES)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (cmd.insert),
        .waddr (chl_pkg::NODE_AW'(node_count_reg)),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            case (cmd.res_kind)
                chl_pkg::RK_FOUND: out_id_reg <= cur_reg;
                chl_pkg::RK_NEW:   out_id_reg <= node_count_reg;
                default:           out_id_reg <= '0;
            endcase
            out_found_reg <= (cmd.res_kind == chl_pkg::RK_FOUND);
            out_full_reg  <= (cmd.res_kind == chl_pkg::RK_FULL);
        end
    end

    always_comb begin
        status.clr_last = (clr_idx_reg == chl_pkg::BKT_AW'(chl_pkg::BUCKETS - 1));
        // links always point to lower ids, so a chain cannot loop
        status.cur_end  = (cur_reg == '0) || (cur_reg > node_count_reg);
        status.match    = (node_rdata[CW-1:0] == x_reg) &&
                          (node_rdata[2*CW-1:CW] == y_reg);
        status.full     = (node_count_reg >= chl_pkg::ID_W'(chl_pkg::MAX_NODES));
        status.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_id    = out_id_reg;
    assign out_found = out_found_reg;
    assign out_full  = out_full_reg;

endmodule

`default_nettype wire

// ----- src/chl_ctrl.sv -----
// ----------------------------------------------------------------------------
// chl_ctrl: sequencing controller
// Steps the datapath through the clearing sweep, the hash multiplies, the
// chain walk, the insert and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module chl_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output chl_pkg::ctrl_cmd_t       cmd,
    input  wire chl_pkg::dp_status_t status
);

    chl_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= chl_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            chl_pkg::ST_CLEAR: begin
                if (status.clr_last) begin
                    state_next = chl_pkg::ST_IDLE;
                end
            end
            chl_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = chl_pkg::ST_TRI;
                end
            end
            chl_pkg::ST_TRI:      state_next = chl_pkg::ST_SUM;
            chl_pkg::ST_SUM:      state_next = chl_pkg::ST_KEY;
            chl_pkg::ST_KEY:      state_next = chl_pkg::ST_M1;
            chl_pkg::ST_M1:       state_next = chl_pkg::ST_M2;
            chl_pkg::ST_M2:       state_next = chl_pkg::ST_M3;
            chl_pkg::ST_M3:       state_next = chl_pkg::ST_M4;
            chl_pkg::ST_M4:       state_next = chl_pkg::ST_M5;
            chl_pkg::ST_M5:       state_next = chl_pkg::ST_M6;
            chl_pkg::ST_M6:       state_next = chl_pkg::ST_BKT;
            chl_pkg::ST_BKT:      state_next = chl_pkg::ST_HEAD_RD;
            chl_pkg::ST_HEAD_RD:  state_next = chl_pkg::ST_HEAD_GOT;
            chl_pkg::ST_HEAD_GOT: state_next = chl_pkg::ST_WALK;
            chl_pkg::ST_WALK: begin
                if (!status.cur_end) begin
                    state_next = chl_pkg::ST_CMP;
                end else if (status.full) begin
                    state_next = chl_pkg::ST_RES_FULL;
                end else begin
                    state_next = chl_pkg::ST_INSERT;
                end
            end
            chl_pkg::ST_CMP: begin
                if (status.match) begin
                    state_next = chl_pkg::ST_RES_FOUND;
                end else begin
                    state_next = chl_pkg::ST_WALK;
                end
            end
            chl_pkg::ST_INSERT: state_next = chl_pkg::ST_RES_NEW;
            chl_pkg::ST_RES_FOUND, chl_pkg::ST_RES_NEW, chl_pkg::ST_RES_FULL: begin
                if (status.out_free) begin
                    state_next = chl_pkg::ST_IDLE;
                end
            end
            default: state_next = chl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.mul_sel  = chl_pkg::MUL_ST;
        cmd.op       = chl_pkg::OP_NONE;
        cmd.res_kind = chl_pkg::RK_FOUND;
        in_ready     = 1'b0;
        case (state_reg)
            chl_pkg::ST_CLEAR: cmd.clr_write = 1'b1;
            chl_pkg::ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            chl_pkg::ST_TRI: begin
                cmd.mul_sel = chl_pkg::MUL_ST;
                cmd.op      = chl_pkg::OP_CROSS;
            end
            chl_pkg::ST_SUM: cmd.op = chl_pkg::OP_TRI;
            chl_pkg::ST_KEY: cmd.op = chl_pkg::OP_KEY;
            chl_pkg::ST_M1:  cmd.mul_sel = chl_pkg::MUL_KLGL;
            chl_pkg::ST_M2: begin
                cmd.mul_sel = chl_pkg::MUL_KHGL;
                cmd.op      = chl_pkg::OP_ACC_LOAD;
            end
            chl_pkg::ST_M3: begin
                cmd.mul_sel = chl_pkg::MUL_KLGH;
                cmd.op      = chl_pkg::OP_ACC_ADD;
            end
            chl_pkg::ST_M4: cmd.op = chl_pkg::OP_ACC_ADD;
            chl_pkg::ST_M5: cmd.mul_sel = chl_pkg::MUL_CLO;
            chl_pkg::ST_M6: begin
                cmd.mul_sel = chl_pkg::MUL_CHI;
                cmd.op      = chl_pkg::OP_CARRY;
            end
            chl_pkg::ST_BKT:      cmd.op = chl_pkg::OP_BUCKET;
            chl_pkg::ST_HEAD_GOT: cmd.cur_head = 1'b1;
            chl_pkg::ST_CMP:      cmd.cur_next = !status.match;
            chl_pkg::ST_INSERT:   cmd.insert = 1'b1;
            chl_pkg::ST_RES_FOUND: begin
                cmd.res_load = status.out_free;
                cmd.res_kind = chl_pkg::RK_FOUND;
            end
            chl_pkg::ST_RES_NEW: begin
                cmd.res_load = status.out_free;
                cmd.res_kind = chl_pkg::RK_NEW;
            end
            chl_pkg::ST_RES_FULL: begin
                cmd.res_load = status.out_free;
                cmd.res_kind = chl_pkg::RK_FULL;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/chl_checker.sv -----
// ----------------------------------------------------------------------------
// chl_checker: port-level checks for the lookup-or-insert block
// Watches the result channel and the configuration port over time.
// ----------------------------------------------------------------------------
`default_nettype none

module chl_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [15:0]                    m_tdata,
    input wire logic [1:0]                     m_tuser,
    input wire logic                           pready
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // found and store-full never together
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("was_found and store_full both set");

    // full store gives id zero, otherwise a real id
    a_full_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == 16'd0)
        else $error("store_full with nonzero id");

    a_id_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tdata[11:0] != 12'd0 && m_tdata[15:12] == 4'd0)
        else $error("bad id on found or inserted point");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind coordinate_hash_lookup_or_insert chl_checker u_chl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);

`default_nettype wire
